>>> src/binary_lz78_decompressor_defines.svh
// Assertion helpers shared by the decompressor RTL.
`ifndef BINARY_LZ78_DECOMPRESSOR_DEFINES_SVH
`define BINARY_LZ78_DECOMPRESSOR_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BLZ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BLZ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/blz_pkg.sv
package blz_pkg;

    localparam int BYTE_W = 8;
    localparam int ACC_W  = 9;
    localparam int HELD_W = 4;
    localparam int ID_W   = 9;

    // One dictionary entry: parent phrase index and the appended bit.
    typedef struct packed {
        logic [BYTE_W-1:0] parent;
        logic              nbit;
    } dict_entry_t;

    // One result beat, without the end-of-run marker.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              stream_ended;
        logic              dict_overflow;
    } emit_item_t;

    // Code width for the given next entry id: 1 + ceil(log2(n)).
    function automatic logic [HELD_W-1:0] code_width(input logic [ID_W-1:0] n);
        logic [ID_W-1:0]   m;
        logic [HELD_W-1:0] k;
        m = n - ID_W'(1);
        k = '0;
        for (int i = 0; i < ID_W; i++) begin
            if (m[i]) begin
                k = HELD_W'(i + 1);
            end
        end
        if (n == '0) begin
            k = '0;
        end
        return k + HELD_W'(1);
    endfunction

endpackage

>>> src/blz_dict.sv
module blz_dict #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  blz_pkg::dict_entry_t  wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output blz_pkg::dict_entry_t  rdata
);
    import blz_pkg::*;

    dict_entry_t mem [0:DEPTH-1];
    dict_entry_t rdata_reg;

    // Write new entries; registered read for the chain walk.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/blz_rstack.sv
module blz_rstack #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic              rdata
);

    logic mem [0:DEPTH-1];
    logic rdata_reg;

    // Push phrase bits leaf first; read back root first.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/blz_emit.sv
module blz_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  blz_pkg::emit_item_t  push_item,
    input  logic                 close_valid,
    output logic                 emit_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_byte_valid,
    output logic                 m_last_of_run,
    output logic                 m_stream_ended,
    output logic                 m_dict_overflow
);
    import blz_pkg::*;

    emit_item_t hold_reg, hold_next;
    logic       hold_v_reg, hold_v_next;
    emit_item_t out_reg, out_next;
    logic       out_last_reg, out_last_next;
    logic       out_v_reg, out_v_next;
    logic       out_free;

    assign out_free   = !out_v_reg || m_ready;
    assign emit_ready = !hold_v_reg || out_free;

    // Hold the newest beat back until it is known whether it ends the run.
    always_comb begin
        hold_next     = hold_reg;
        hold_v_next   = hold_v_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg && !m_ready;
        if (push_valid && emit_ready) begin
            if (hold_v_reg) begin
                out_next      = hold_reg;
                out_last_next = 1'b0;
                out_v_next    = 1'b1;
            end
            hold_next   = push_item;
            hold_v_next = 1'b1;
        end else if (close_valid && emit_ready) begin
            if (hold_v_reg) begin
                out_next      = hold_reg;
                out_last_next = 1'b1;
                out_v_next    = 1'b1;
            end
            hold_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid         = out_v_reg;
    assign m_out_byte      = out_reg.out_byte;
    assign m_byte_valid    = out_reg.byte_valid;
    assign m_last_of_run   = out_last_reg;
    assign m_stream_ended  = out_reg.stream_ended;
    assign m_dict_overflow = out_reg.dict_overflow;

endmodule

>>> src/binary_lz78_decompressor.sv
// Binary LZ78 decompressor. Each input beat is one compressed byte, read most
// significant bit first into variable-width codes (1 + ceil(log2(next id))
// bits: parent index over one new bit). Each code adds a dictionary entry and
// its phrase is written out MSB first; every completed 8 bits leave as one
// data beat, and partial trailing bits are never sent. An end code (index at
// or above the next id) or a code arriving with a full dictionary sets
// stream_ended or dict_overflow, sends one status beat (byte_valid low) and
// makes the block drop all later input until reset. last_of_run marks the
// final beat caused by an input byte; a byte that completes nothing yields no
// beat. The dictionary chain is read one entry per cycle from a synchronous
// memory, and the phrase is then read back from a reversal stack one bit per
// cycle, pausing while the output stalls. The dictionary memories need no
// clearing after reset.
`include "binary_lz78_decompressor_defines.svh"

module binary_lz78_decompressor #(
    parameter int DICT_ENTRIES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_last_of_run,
    output logic       m_stream_ended,
    output logic       m_dict_overflow
);
    import blz_pkg::*;

    localparam int ADDR_W = $clog2(DICT_ENTRIES);
    localparam logic [ID_W-1:0] DICT_LIMIT = ID_W'(DICT_ENTRIES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BIT   = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_POP   = 3'd3;
    localparam logic [2:0] ST_FLAG  = 3'd4;
    localparam logic [2:0] ST_CLOSE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [3:0]        bits_left_reg, bits_left_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [ADDR_W-1:0] sp_reg, sp_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              ended_reg, ended_next;
    logic              full_reg, full_next;

    // Decode path
    logic [ACC_W-1:0]  acc_shift;
    logic [HELD_W-1:0] held_inc;
    logic [BYTE_W-1:0] idx_val;

    // Pop path
    logic              consume;
    logic              issue;
    logic [BYTE_W-1:0] shift_new;

    // Memory ports
    logic              dict_we, dict_re;
    logic [ADDR_W-1:0] dict_waddr, dict_raddr;
    dict_entry_t       dict_wdata, dict_rdata;
    logic              stk_we, stk_re, stk_wdata, stk_rdata;
    logic [ADDR_W-1:0] stk_waddr, stk_raddr;

    // Result path
    logic              push_valid, close_valid, emit_ready;
    emit_item_t        push_item;

    assign acc_shift = {acc_reg[ACC_W-2:0], byte_reg[BYTE_W-1]};
    assign held_inc  = held_reg + HELD_W'(1);
    assign idx_val   = acc_shift[ACC_W-1:1];
    assign shift_new = {shift_reg[BYTE_W-2:0], stk_rdata};
    assign consume   = (state_reg == ST_POP) && rd_pend_reg
                       && ((cnt_reg != 3'd7) || emit_ready);
    assign issue     = (state_reg == ST_POP) && (sp_reg != '0)
                       && (!rd_pend_reg || consume);

    assign s_ready = (state_reg == ST_IDLE);

    // Sequence: shift code bits, decode, walk the chain, pop the phrase; an end or overflow code sends a status beat.
    always_comb begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        bits_left_next = bits_left_reg;
        acc_next       = acc_reg;
        held_next      = held_reg;
        next_id_next   = next_id_reg;
        sp_next        = sp_reg;
        rd_pend_next   = rd_pend_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        ended_next     = ended_reg;
        full_next      = full_reg;

        dict_we    = 1'b0;
        dict_waddr = next_id_reg[ADDR_W-1:0];
        dict_wdata = '{parent: idx_val, nbit: acc_shift[0]};
        dict_re    = 1'b0;
        dict_raddr = idx_val[ADDR_W-1:0];
        stk_we     = 1'b0;
        stk_waddr  = sp_reg;
        stk_wdata  = dict_rdata.nbit;
        stk_re     = issue;
        stk_raddr  = sp_reg - ADDR_W'(1);

        push_valid  = 1'b0;
        push_item   = '{out_byte: shift_new, byte_valid: 1'b1,
                        stream_ended: ended_reg, dict_overflow: full_reg};
        close_valid = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && !ended_reg && !full_reg) begin
                    byte_next      = s_data_byte;
                    bits_left_next = 4'd8;
                    state_next     = ST_BIT;
                end
            end
            ST_BIT: begin
                byte_next      = {byte_reg[BYTE_W-2:0], 1'b0};
                bits_left_next = bits_left_reg - 4'd1;
                if (held_inc >= code_width(next_id_reg)) begin
                    acc_next  = '0;
                    held_next = '0;
                    if ({1'b0, idx_val} >= next_id_reg) begin
                        ended_next = 1'b1;
                        state_next = ST_FLAG;
                    end else if (next_id_reg >= DICT_LIMIT) begin
                        full_next  = 1'b1;
                        state_next = ST_FLAG;
                    end else begin
                        // Store the entry and seed the stack with its own bit.
                        dict_we      = 1'b1;
                        stk_we       = 1'b1;
                        stk_waddr    = '0;
                        stk_wdata    = acc_shift[0];
                        sp_next      = ADDR_W'(1);
                        rd_pend_next = 1'b0;
                        next_id_next = next_id_reg + ID_W'(1);
                        if (idx_val == '0) begin
                            state_next = ST_POP;
                        end else begin
                            dict_re    = 1'b1;
                            state_next = ST_WALK;
                        end
                    end
                end else begin
                    acc_next  = acc_shift;
                    held_next = held_inc;
                    if (bits_left_reg == 4'd1) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_WALK: begin
                // Push this entry's bit and follow its parent.
                stk_we  = 1'b1;
                sp_next = sp_reg + ADDR_W'(1);
                if (dict_rdata.parent == '0) begin
                    rd_pend_next = 1'b0;
                    state_next   = ST_POP;
                end else begin
                    dict_re    = 1'b1;
                    dict_raddr = dict_rdata.parent[ADDR_W-1:0];
                end
            end
            ST_POP: begin
                if (consume) begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        push_valid = 1'b1;
                        shift_next = '0;
                    end else begin
                        shift_next = shift_new;
                    end
                end
                if (issue) begin
                    sp_next = sp_reg - ADDR_W'(1);
                end
                rd_pend_next = issue || (rd_pend_reg && !consume);
                if ((sp_reg == '0) && !rd_pend_reg) begin
                    state_next = (bits_left_reg == 4'd0) ? ST_CLOSE : ST_BIT;
                end
            end
            ST_FLAG: begin
                push_item = '{out_byte: '0, byte_valid: 1'b0,
                              stream_ended: ended_reg, dict_overflow: full_reg};
                push_valid = 1'b1;
                if (emit_ready) begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                close_valid = 1'b1;
                if (emit_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            held_reg    <= '0;
            next_id_reg <= ID_W'(1);
            rd_pend_reg <= 1'b0;
            shift_reg   <= '0;
            cnt_reg     <= '0;
            ended_reg   <= 1'b0;
            full_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            held_reg    <= held_next;
            next_id_reg <= next_id_next;
            rd_pend_reg <= rd_pend_next;
            shift_reg   <= shift_next;
            cnt_reg     <= cnt_next;
            ended_reg   <= ended_next;
            full_reg    <= full_next;
        end
        byte_reg      <= byte_next;
        bits_left_reg <= bits_left_next;
        sp_reg        <= sp_next;
    end

    blz_dict #(
        .DEPTH  (DICT_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_dict (
        .aclk  (aclk),
        .we    (dict_we),
        .waddr (dict_waddr),
        .wdata (dict_wdata),
        .re    (dict_re),
        .raddr (dict_raddr),
        .rdata (dict_rdata)
    );

    blz_rstack #(
        .DEPTH  (DICT_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_rstack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    blz_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push_valid      (push_valid),
        .push_item       (push_item),
        .close_valid     (close_valid),
        .emit_ready      (emit_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_last_of_run   (m_last_of_run),
        .m_stream_ended  (m_stream_ended),
        .m_dict_overflow (m_dict_overflow)
    );

    `BLZ_ASSERT_ALWAYS(a_id_in_range, aclk, aresetn, (next_id_reg <= DICT_LIMIT), "next id beyond dictionary")
    `BLZ_ASSERT_IMPLY(a_walk_reads_written, aclk, aresetn, dict_re, (ID_W'(dict_raddr) < next_id_reg), "dictionary read of unwritten entry")
    `BLZ_ASSERT_NEXT(a_ended_sticky, aclk, aresetn, ended_reg, ended_reg, "ended flag cleared without reset")
    `BLZ_ASSERT_IMPLY(a_data_beat_clean, aclk, aresetn, (m_valid && m_byte_valid), (!m_stream_ended && !m_dict_overflow), "data beat carries status flag")

endmodule

>>> tb/tb_binary_lz78_decompressor.sv
`timescale 1ns / 1ps

module tb_binary_lz78_decompressor;
    import blz_pkg::*;

    localparam int unsigned DICT_N       = 256;
    localparam int unsigned CYCLE_CAP    = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned SHOW_MAX     = 10;

    // One beat of the result channel.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_of_run;
        logic              stream_ended;
        logic              dict_overflow;
    } lz_beat_t;

    // Bit-level decoder of the compressed stream plus the queue of beats it still owes.
    class lz78_scoreboard;
        bit [7:0]    parent_of [DICT_N];
        bit          bit_of [DICT_N];
        int unsigned next_id   = 1;
        bit [8:0]    code_acc  = '0;
        int unsigned code_held = 0;
        bit [7:0]    out_shift = '0;
        int unsigned out_count = 0;
        bit          ended     = 1'b0;
        bit          full      = 1'b0;
        lz_beat_t    step_beats[$];
        lz_beat_t    owed_beats[$];
        int unsigned bad_beats = 0;

        // Code width is one index bit per doubling of the next id, plus the new bit.
        static function int unsigned code_len(int unsigned n);
            int unsigned k;
            k = 0;
            while (k < 9 && (1 << k) < n) k++;
            return k + 1;
        endfunction

        function bit halted();
            return ended || full;
        endfunction

        function void put_beat(bit [7:0] b, bit v);
            lz_beat_t beat;
            beat.out_byte      = b;
            beat.byte_valid    = v;
            beat.last_of_run   = 1'b0;
            beat.stream_ended  = ended;
            beat.dict_overflow = full;
            step_beats.push_back(beat);
        endfunction

        // Add one entry and shift its phrase out, root first.
        function void decode_code();
            bit [7:0] idx;
            bit       nb;
            bit [7:0] id;
            bit [7:0] cur;
            bit       chain[$];
            idx = code_acc[8:1];
            nb  = code_acc[0];
            if (idx >= next_id) begin
                ended = 1'b1;
                return;
            end
            if (next_id >= DICT_N) begin
                full = 1'b1;
                return;
            end
            id            = 8'(next_id);
            parent_of[id] = idx;
            bit_of[id]    = nb;
            next_id++;
            cur = id;
            while (cur != 0) begin
                chain.push_front(bit_of[cur]);
                cur = parent_of[cur];
            end
            foreach (chain[j]) begin
                out_shift = {out_shift[6:0], chain[j]};
                out_count++;
                if (out_count == 8) begin
                    put_beat(out_shift, 1'b1);
                    out_shift = '0;
                    out_count = 0;
                end
            end
        endfunction

        // Note an accepted input byte and queue the beats it causes.
        function void decode_byte(bit [7:0] din);
            lz_beat_t tail;
            if (halted()) return;
            step_beats.delete();
            for (int i = 7; i >= 0; i--) begin
                if (halted()) break;
                code_acc = {code_acc[7:0], din[i]};
                code_held++;
                if (code_held >= code_len(next_id)) begin
                    decode_code();
                    code_acc  = '0;
                    code_held = 0;
                end
            end
            if (halted()) put_beat(8'h00, 1'b0);
            if (step_beats.size() > 0) begin
                tail = step_beats.pop_back();
                tail.last_of_run = 1'b1;
                step_beats.push_back(tail);
            end
            foreach (step_beats[j]) owed_beats.push_back(step_beats[j]);
        endfunction

        // Compare an accepted beat against the oldest owed beat.
        function void match_beat(lz_beat_t got);
            lz_beat_t want;
            if (owed_beats.size() == 0) begin
                bad_beats++;
                if (bad_beats <= SHOW_MAX) begin
                    $display("extra beat: byte=%02h valid=%0b last=%0b ended=%0b ovf=%0b",
                             got.out_byte, got.byte_valid, got.last_of_run,
                             got.stream_ended, got.dict_overflow);
                end
                return;
            end
            want = owed_beats.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.last_of_run !== want.last_of_run ||
                    got.stream_ended !== want.stream_ended ||
                    got.dict_overflow !== want.dict_overflow) begin
                bad_beats++;
                if (bad_beats <= SHOW_MAX) begin
                    $display("mismatch: exp byte=%02h valid=%0b last=%0b ended=%0b ovf=%0b",
                             want.out_byte, want.byte_valid, want.last_of_run,
                             want.stream_ended, want.dict_overflow);
                    $display("          got byte=%02h valid=%0b last=%0b ended=%0b ovf=%0b",
                             got.out_byte, got.byte_valid, got.last_of_run,
                             got.stream_ended, got.dict_overflow);
                end
            end
        endfunction
    endclass

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte  = 8'h00;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_last_of_run;
    logic       m_stream_ended;
    logic       m_dict_overflow;

    lz78_scoreboard sb;
    lz78_scoreboard probe;
    bit             code_bits[$];
    logic [7:0]     byte_stream[$];
    int unsigned    gen_next = 1;
    int unsigned    directed_len;
    int             phase = 0;
    int unsigned    cycles = 0;

    binary_lz78_decompressor #(
        .DICT_ENTRIES(DICT_N)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_last_of_run  (m_last_of_run),
        .m_stream_ended (m_stream_ended),
        .m_dict_overflow(m_dict_overflow)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Append one code: index bits MSB first, then the new bit.
    function automatic void push_code(int unsigned idx, bit nb);
        int unsigned w;
        w = lz78_scoreboard::code_len(gen_next);
        for (int i = int'(w) - 2; i >= 0; i--) code_bits.push_back(idx[i]);
        code_bits.push_back(nb);
        gen_next++;
    endfunction

    // Turn whole groups of 8 code bits into stream bytes.
    function automatic void pack_bytes();
        logic [7:0] b;
        while (code_bits.size() >= 8) begin
            for (int i = 7; i >= 0; i--) b[i] = code_bits.pop_front();
            byte_stream.push_back(b);
            probe.decode_byte(b);
        end
    endfunction

    function automatic void pad_to_byte(bit all_ones);
        while (code_bits.size() % 8 != 0) begin
            code_bits.push_back(all_ones ? 1'b1 : 1'($urandom_range(1)));
        end
    endfunction

    // Favor the newest entry to grow long phrases; otherwise root or any entry.
    function automatic int unsigned pick_parent();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return gen_next - 1;
        if (roll < 55) return 0;
        return $urandom_range(gen_next - 1);
    endfunction

    function automatic int unsigned idle_pct(bit sender_side);
        case (phase)
            0: begin
                return sender_side ? 37 : 51;
            end
            1: begin
                return sender_side ? 51 : 37;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    // Receiver: stall at random, change ready at the falling edge.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= idle_pct(1'b0));
    end

    // Check every beat taken at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.match_beat(lz_beat_t'({m_out_byte, m_byte_valid, m_last_of_run,
                                      m_stream_ended, m_dict_overflow}));
        end
    end

    // Watchdog on total run length.
    initial begin
        while (cycles < CYCLE_CAP) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned noise;
        sb    = new();
        probe = new();

        // All-zero codes: zero bytes, several codes in one byte, a quiet first byte.
        repeat (8) push_code(0, 1'b0);
        push_code(0, 1'b1);
        push_code(gen_next - 1, 1'b1);
        // Long chain so one code spills over several output beats.
        repeat (22) push_code(gen_next - 1, gen_next[0]);
        pack_bytes();
        directed_len = byte_stream.size();

        // Well-formed random codes, then a broken tail.
        while (gen_next < DICT_N && byte_stream.size() < 110) begin
            push_code(pick_parent(), 1'($urandom_range(1)));
            pack_bytes();
        end
        pad_to_byte(1'b0);
        pack_bytes();
        noise = 0;
        while (!probe.halted() && noise < 40) begin
            byte_stream.push_back(8'($urandom_range(255)));
            probe.decode_byte(byte_stream[$]);
            noise++;
        end
        // Trailing bytes are dropped by the halted block.
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(8'h00);
        repeat (4) byte_stream.push_back(8'($urandom_range(255)));

        // Hold reset, release at a falling edge.
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < byte_stream.size(); i++) begin
            // Hold off once until the decoder has drained.
            if (i == directed_len && sb.owed_beats.size() != 0) begin
                s_valid = 1'b0;
                while (sb.owed_beats.size() != 0) @(negedge aclk);
            end
            phase = i * 3 / byte_stream.size();
            while ($urandom_range(99) < idle_pct(1'b1)) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
            s_valid     = 1'b1;
            s_data_byte = byte_stream[i];
            do @(posedge aclk); while (!s_ready);
            sb.decode_byte(byte_stream[i]);
            @(negedge aclk);
        end
        s_valid = 1'b0;

        // Drain owed beats, then watch for strays.
        while (sb.owed_beats.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (sb.bad_beats == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/blz_pkg.sv
src/blz_dict.sv
src/blz_rstack.sv
src/blz_emit.sv
src/binary_lz78_decompressor.sv
tb/tb_binary_lz78_decompressor.sv
